// ----- sv/sorter_pkg.sv -----
// Shared constants and types for the stream sorter.
package sorter_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_FILL,
    ST_OUTER,
    ST_RD,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  // Map a two's complement word to an unsigned key with the same order.
  function automatic logic [31:0] order_key(input logic [31:0] v);
    return v ^ 32'h8000_0000;
  endfunction

endpackage

// ----- sv/stream_sorter_ascending_top.sv -----
// Stream sorter top level: collect a run, insertion-sort it in memory, emit it.
//
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_value, in_last
// out_    | output    | out_valid/out_stall| out_sorted_value, out_last_out, out_overflow
//
// Fill: one item per cycle, no result until the item marked last.
// Sort: element i takes a fetch (ST_OUTER) and a read (ST_RD), then ST_CMP shifts each
//   larger element up one entry and finally writes element i into place.
// Emit: ST_EMIT_RD reads the first entry, then one result per cycle while
//   out_stall is low; a stalled result holds and the emit waits for it.
// Input is stalled during sort and emit; it reopens once the final result is loaded
// into the output register. Reset (rst_n low, synchronous) empties the run; the
// store itself is not cleared.
module stream_sorter_ascending_top #(
  parameter int CAPACITY = sorter_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] in_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_sorted_value,
  output logic        out_last_out,
  output logic        out_overflow
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  sorter_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] i_r, i_nxt;   // outer index
  logic [CW-1:0] j_r, j_nxt;   // insertion position
  logic [31:0]   cur_r, cur_nxt;
  logic [CW-1:0] k_r, k_nxt;   // emit index
  logic [31:0]   out_val_r, out_val_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  sorter_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sorter_pkg::ST_FILL;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    cur_r <= cur_nxt;
    k_r <= k_nxt;
    out_val_r <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    i_nxt = i_r;
    j_nxt = j_r;
    cur_nxt = cur_r;
    k_nxt = k_r;
    out_val_nxt = out_val_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt = out_ovf_r;
    // a held result clears once taken
    out_valid_nxt = out_valid_r & out_stall;
    we = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = in_value;
    raddr = i_r[AW-1:0];
    in_stall = 1'b1;
    unique case (state_r)
      sorter_pkg::ST_FILL: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (count_r < CW'(CAPACITY)) begin
            we = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt = CW'(1);
            state_nxt = sorter_pkg::ST_OUTER;
          end
        end
      end
      sorter_pkg::ST_OUTER: begin
        // Fetch element i as the one to insert
        if (i_r >= count_r) begin
          k_nxt = '0;
          state_nxt = sorter_pkg::ST_EMIT_RD;
        end else begin
          raddr = i_r[AW-1:0];
          state_nxt = sorter_pkg::ST_RD;
        end
      end
      sorter_pkg::ST_RD: begin
        // rdata holds element i
        cur_nxt = rdata;
        j_nxt = i_r;
        raddr = AW'(i_r - CW'(1));
        state_nxt = sorter_pkg::ST_CMP;
      end
      sorter_pkg::ST_CMP: begin
        // rdata holds element j-1: shift it up or drop cur in place
        priority if (j_r == '0) begin
          // Reached the bottom: cur lands at entry 0
          we = 1'b1;
          waddr = '0;
          wdata = cur_r;
          i_nxt = i_r + CW'(1);
          state_nxt = sorter_pkg::ST_OUTER;
        end else if (sorter_pkg::order_key(rdata) > sorter_pkg::order_key(cur_r)) begin
          we = 1'b1;
          waddr = j_r[AW-1:0];
          wdata = rdata;
          j_nxt = j_r - CW'(1);
          raddr = AW'(j_r - CW'(2));
        end else begin
          we = 1'b1;
          waddr = j_r[AW-1:0];
          wdata = cur_r;
          i_nxt = i_r + CW'(1);
          state_nxt = sorter_pkg::ST_OUTER;
        end
      end
      sorter_pkg::ST_EMIT_RD: begin
        raddr = k_r[AW-1:0];
        state_nxt = sorter_pkg::ST_EMIT;
      end
      sorter_pkg::ST_EMIT: begin
        // rdata holds element k; load it once the output register is free
        raddr = k_r[AW-1:0];
        if (!out_valid_r || !out_stall) begin
          out_val_nxt = rdata;
          out_last_nxt = (k_r + CW'(1) == count_r);
          out_ovf_nxt = drop_r;
          out_valid_nxt = 1'b1;
          k_nxt = k_r + CW'(1);
          raddr = AW'(k_r + CW'(1));
          if (out_last_nxt) begin
            count_nxt = '0;
            drop_nxt = 1'b0;
            state_nxt = sorter_pkg::ST_FILL;
          end
        end
      end
      default: state_nxt = sorter_pkg::ST_FILL;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_sorted_value = out_val_r;
  assign out_last_out = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule

// ----- sv/sorter_mem.sv -----
// Element store: one write port, one registered read port.
module sorter_mem #(
  parameter int CAPACITY = sorter_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [31:0]       wdata,
  input  logic [AW-1:0]     raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [CAPACITY];

  // Synchronous write and read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- dv/stream_sorter_ascending_top_tb.sv -----
// Testbench for stream_sorter_ascending_top: random and directed runs, predicted sort.
module stream_sorter_ascending_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = sorter_pkg::CAPACITY_DEF;

  // Result item as predicted
  typedef struct {
    logic signed [31:0] value;
    logic               last_out;
    logic               overflow;
  } sorted_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_sorted_value;
  logic out_last_out;
  logic out_overflow;

  // Predictor state
  logic signed [31:0] run_store[$];
  logic               run_dropped = 1'b0;
  sorted_item_t       pending_sorted[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int runs_sent = 0;
  int overflow_runs = 0;
  int stall_left = 0;
  bit out_stall_busy = 1'b0;

  stream_sorter_ascending_top u_top (.*);

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Store or drop one value; on last, queue the run in ascending order
  task automatic predict_item(input logic signed [31:0] v, input logic lst);
    sorted_item_t r;
    logic signed [31:0] key;
    int j;
    if (run_store.size() < CAP) begin
      // stable insertion: place after all values <= v
      j = run_store.size();
      while (j > 0 && run_store[j-1] > v) j--;
      run_store.insert(j, v);
    end else begin
      run_dropped = 1'b1;
    end
    if (lst) begin
      runs_sent++;
      if (run_dropped) overflow_runs++;
      foreach (run_store[k]) begin
        key = run_store[k];
        r.value = key;
        r.last_out = (k == run_store.size() - 1);
        r.overflow = run_dropped;
        pending_sorted.push_back(r);
      end
      run_store.delete();
      run_dropped = 1'b0;
    end
  endtask

  // Random gap: mostly short, sometimes long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one item and wait for acceptance; valid stays up until the next call
  task automatic send_item(input logic signed [31:0] v, input logic lst, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(v, lst);
    items_sent++;
  endtask

  // Random value biased toward extremes and duplicates
  function automatic logic signed [31:0] pick_value();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 7)) - 4;
      default: return $signed($urandom());
    endcase
  endfunction

  // Send one run of n items, the last one marked
  task automatic send_run(input int n, input bit gaps);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1, gaps);
  endtask

  // Idle the input and wait until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    sorted_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_sorted.size() == 0) begin
        $error("unexpected result value=%0d", out_sorted_value);
        errors++;
      end else begin
        e = pending_sorted.pop_front();
        if (out_sorted_value !== e.value) begin
          $error("sorted_value expected %0d actual %0d", e.value, out_sorted_value);
          errors++;
        end
        if (out_last_out !== e.last_out) begin
          $error("last_out expected %0b actual %0b", e.last_out, out_last_out);
          errors++;
        end
        if (out_overflow !== e.overflow) begin
          $error("overflow expected %0b actual %0b", e.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern: stretches of stall, mostly short, a few long
  always @(posedge clk) begin
    if (out_stall_busy) begin
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = gap_len();
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Directed: extremes, single-item run, duplicates, every bit of value
  task automatic test_directed();
    send_item(32'sh7fff_ffff, 1'b1, 0);
    send_item(32'sh8000_0000, 1'b0, 0);
    send_item(32'sh7fff_ffff, 1'b0, 0);
    send_item(32'sh0000_0000, 1'b0, 0);
    send_item(-32'sd1, 1'b0, 0);
    send_item(32'sh5555_5555, 1'b0, 0);
    send_item(32'shaaaa_aaaa, 1'b0, 0);
    send_item(32'sd5, 1'b0, 0);
    send_item(32'sd5, 1'b0, 0);
    send_item(32'sh8000_0000, 1'b1, 0);
    wait_drained();
  endtask

  // Exactly full store, then two overflowing runs (with and without gaps), each dropping its last item
  task automatic test_capacity();
    send_run(CAP, 0);
    send_run(CAP + 3, 1);
    send_run(CAP + 1, 0);
    wait_drained();
  endtask

  // Random runs, mostly short, with random stalls on the result side
  task automatic test_random_runs();
    int n;
    out_stall_busy = 1'b1;
    while (items_sent < 370) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 2, CAP + 4)
                                      : $urandom_range(1, 12);
      send_run(n, 1);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    wait_drained();
    out_stall_busy = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random_runs();
    repeat (50) @(posedge clk);
    $display("Sent %0d items in %0d runs (%0d with dropped values), checked %0d results.",
             items_sent, runs_sent, overflow_runs, results_seen);
    if (errors == 0 && pending_sorted.size() == 0)
      $display("stream_sorter_ascending_top verification clean");
    else
      $display("stream_sorter_ascending_top verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("stream_sorter_ascending_top verification failed");
    $finish;
  end
endmodule
